@@ rtl/volume_axis_difference_core_defines.svh @@
// Assertion macros for the checker of the volume difference core.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef VOLUME_AXIS_DIFFERENCE_CORE_DEFINES_SVH
`define VOLUME_AXIS_DIFFERENCE_CORE_DEFINES_SVH

// Consequent must hold in the clock after the antecedent.
`define VAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define VAD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/vad_pkg.sv @@
package vad_pkg;

    // Sample and result widths
    localparam int SAMPLE_BITS   = 16;
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;

    // Volume limits
    localparam int MAX_X         = 256;
    localparam int MAX_Y         = 256;
    localparam int MAX_Z         = 256;
    localparam int X_BITS        = $clog2(MAX_X);
    localparam int Y_BITS        = $clog2(MAX_Y);
    localparam int Z_BITS        = $clog2(MAX_Z);

    // Configuration register port
    localparam int SIZE_BITS     = 9;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int AXIS_BITS     = 2;

    // Delay line holds up to one plane
    localparam int STORE_DEPTH   = MAX_X * MAX_Y;
    localparam int ADDR_BITS     = $clog2(STORE_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AXIS,
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z
    } t_cfg_idx;

    // Axis codes; any other code selects z
    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    // Per-transaction command from control to datapath
    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] addr;
        logic                 emit;
        logic                 zero;
        logic                 last;
    } t_step;

    // Clamp a size register and return the effective size minus one
    function automatic logic [X_BITS-1:0] clamp_x(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] vm1;
        vm1 = v - SIZE_BITS'(1);
        if (v == '0)
            return '0;
        else if (v > SIZE_BITS'(MAX_X))
            return X_BITS'(MAX_X - 1);
        else
            return vm1[X_BITS-1:0];
    endfunction

    function automatic logic [Y_BITS-1:0] clamp_y(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] vm1;
        vm1 = v - SIZE_BITS'(1);
        if (v == '0)
            return '0;
        else if (v > SIZE_BITS'(MAX_Y))
            return Y_BITS'(MAX_Y - 1);
        else
            return vm1[Y_BITS-1:0];
    endfunction

    function automatic logic [Z_BITS-1:0] clamp_z(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] vm1;
        vm1 = v - SIZE_BITS'(1);
        if (v == '0)
            return '0;
        else if (v > SIZE_BITS'(MAX_Z))
            return Z_BITS'(MAX_Z - 1);
        else
            return vm1[Z_BITS-1:0];
    endfunction

endpackage

@@ rtl/vad_ifs.sv @@
// Voxel request channel
interface vad_in_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic signed [vad_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

// Difference result channel
interface vad_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vad_pkg::DIFF_BITS-1:0] difference;
    logic                                 last;

    modport source (output valid, output difference, output last, input ready);
    modport sink   (input valid, input difference, input last, output ready);
endinterface

// Configuration write channel
interface vad_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vad_pkg::CFG_IDX_BITS-1:0]    index;
    logic [vad_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/volume_axis_difference_core.sv @@
// Forward-difference gradient of a raster-ordered volume (x fastest) along
// the configured axis. One transaction is taken per clock unless the output
// stalls; a result passes from the input stage, which waits on the registered
// read of a single-port 65536 x 16 delay ring, to the output register.
// Results start once one neighbour distance of voxels has arrived (1, size_x
// or size_x*size_y); voxels on the far boundary give zero, and after the
// final voxel each drain request releases one trailing result, the final one
// marked last. Configuration writes restart the stream and must be made
// while the core is idle. The ring needs no clearing after reset.
module volume_axis_difference_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vad_in_if.sink    i_in,
    vad_cfg_if.sink   i_cfg,
    vad_out_if.source o_out
);

    logic           in_ready;
    logic           accept;
    vad_pkg::t_step step;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    vad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_accept   (accept),
        .i_req_type (i_in.req_type),
        .o_step     (step)
    );

    vad_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_in.sample),
        .i_step     (step),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule

@@ rtl/vad_ctrl.sv @@
module vad_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vad_cfg_if.sink        i_cfg,
    input  logic           i_accept,
    input  logic           i_req_type,
    output vad_pkg::t_step o_step
);

    // Configuration registers
    logic [vad_pkg::AXIS_BITS-1:0] r_axis;
    logic [vad_pkg::SIZE_BITS-1:0] r_size_x, r_size_y, r_size_z;

    // Stream state
    logic [vad_pkg::X_BITS-1:0]    r_in_col, n_in_col, r_out_col, n_out_col;
    logic [vad_pkg::Y_BITS-1:0]    r_in_row, n_in_row, r_out_row, n_out_row;
    logic [vad_pkg::Z_BITS-1:0]    r_in_plane, n_in_plane, r_out_plane, n_out_plane;
    logic [vad_pkg::ADDR_BITS-1:0] r_slot, n_slot;
    logic                          r_filled, n_filled;
    logic                          r_in_done, n_in_done;
    logic                          r_out_done, n_out_done;

    // Effective sizes and neighbour distance
    logic [vad_pkg::X_BITS-1:0]    ex_m1;
    logic [vad_pkg::Y_BITS-1:0]    ey_m1;
    logic [vad_pkg::Z_BITS-1:0]    ez_m1;
    logic [vad_pkg::X_BITS:0]      ex_n;
    logic [vad_pkg::Y_BITS:0]      ey_n;
    logic [vad_pkg::X_BITS+vad_pkg::Y_BITS+1:0] plane_n;
    logic [vad_pkg::ADDR_BITS-1:0] d_m1;

    logic cfg_wr;
    logic sample_act;
    logic emit_s;
    logic emit_d;
    logic emit;
    logic boundary;
    logic out_last;
    logic in_last;

    // Take register writes whenever out of reset
    assign i_cfg.ready = i_rst_n;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    assign ex_m1   = vad_pkg::clamp_x(r_size_x);
    assign ey_m1   = vad_pkg::clamp_y(r_size_y);
    assign ez_m1   = vad_pkg::clamp_z(r_size_z);
    assign ex_n    = {1'b0, ex_m1} + (vad_pkg::X_BITS+1)'(1);
    assign ey_n    = {1'b0, ey_m1} + (vad_pkg::Y_BITS+1)'(1);
    assign plane_n = ex_n * ey_n;

    // Distance minus one selects the ring wrap point
    always_comb begin
        unique case (r_axis)
            vad_pkg::AXIS_X: d_m1 = '0;
            vad_pkg::AXIS_Y: d_m1 = vad_pkg::ADDR_BITS'(ex_m1);
            default:         d_m1 = vad_pkg::ADDR_BITS'(plane_n - 1'b1);
        endcase
    end

    // Far boundary of the result position along the chosen axis
    always_comb begin
        unique case (r_axis)
            vad_pkg::AXIS_X: boundary = (r_out_col == ex_m1);
            vad_pkg::AXIS_Y: boundary = (r_out_row == ey_m1);
            default:         boundary = (r_out_plane == ez_m1);
        endcase
    end

    assign out_last = (r_out_col == ex_m1) && (r_out_row == ey_m1) && (r_out_plane == ez_m1);
    assign in_last  = (r_in_col == ex_m1) && (r_in_row == ey_m1) && (r_in_plane == ez_m1);

    // Classify the transaction
    assign sample_act = i_accept && (i_req_type == vad_pkg::REQ_SAMPLE) && !r_in_done;
    assign emit_s     = sample_act && r_filled;
    assign emit_d     = i_accept && (i_req_type == vad_pkg::REQ_DRAIN) && r_in_done
                        && !r_out_done;
    assign emit       = emit_s || emit_d;

    assign o_step.wr_en = sample_act;
    assign o_step.addr  = r_slot;
    assign o_step.emit  = emit;
    assign o_step.zero  = emit_d || boundary;
    assign o_step.last  = out_last;

    // Next stream state
    always_comb begin
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_in_plane  = r_in_plane;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_plane = r_out_plane;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_in_done   = r_in_done;
        n_out_done  = r_out_done;

        if (cfg_wr) begin
            n_in_col    = '0;
            n_in_row    = '0;
            n_in_plane  = '0;
            n_out_col   = '0;
            n_out_row   = '0;
            n_out_plane = '0;
            n_slot      = '0;
            n_filled    = 1'b0;
            n_in_done   = 1'b0;
            n_out_done  = 1'b0;
        end else begin
            // Advance input position and ring slot
            if (sample_act) begin
                if (in_last)
                    n_in_done = 1'b1;
                if (r_in_col == ex_m1) begin
                    n_in_col = '0;
                    if (r_in_row == ey_m1) begin
                        n_in_row   = '0;
                        n_in_plane = r_in_plane + 1'b1;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (r_slot == d_m1) begin
                    n_slot   = '0;
                    n_filled = 1'b1;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            // Advance result position
            if (emit) begin
                if (out_last)
                    n_out_done = 1'b1;
                if (r_out_col == ex_m1) begin
                    n_out_col = '0;
                    if (r_out_row == ey_m1) begin
                        n_out_row   = '0;
                        n_out_plane = r_out_plane + 1'b1;
                    end else begin
                        n_out_row = r_out_row + 1'b1;
                    end
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= vad_pkg::AXIS_X;
            r_size_x <= vad_pkg::SIZE_BITS'(vad_pkg::MAX_X);
            r_size_y <= vad_pkg::SIZE_BITS'(vad_pkg::MAX_Y);
            r_size_z <= vad_pkg::SIZE_BITS'(vad_pkg::MAX_Z);
        end else if (cfg_wr) begin
            unique case (vad_pkg::t_cfg_idx'(i_cfg.index))
                vad_pkg::CFG_AXIS:   r_axis   <= i_cfg.data[vad_pkg::AXIS_BITS-1:0];
                vad_pkg::CFG_SIZE_X: r_size_x <= i_cfg.data;
                vad_pkg::CFG_SIZE_Y: r_size_y <= i_cfg.data;
                vad_pkg::CFG_SIZE_Z: r_size_z <= i_cfg.data;
            endcase
        end
    end

    // Stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_plane  <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_plane <= '0;
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_in_done   <= 1'b0;
            r_out_done  <= 1'b0;
        end else begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_in_plane  <= n_in_plane;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_out_plane <= n_out_plane;
            r_slot      <= n_slot;
            r_filled    <= n_filled;
            r_in_done   <= n_in_done;
            r_out_done  <= n_out_done;
        end
    end

endmodule

@@ rtl/vad_datapath.sv @@
module vad_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [vad_pkg::SAMPLE_BITS-1:0] i_sample,
    input  vad_pkg::t_step                         i_step,
    output logic                                   o_in_ready,
    vad_out_if.source                              o_out
);

    // Delay ring, one plane deep
    logic [vad_pkg::SAMPLE_BITS-1:0] mem [vad_pkg::STORE_DEPTH];
    logic [vad_pkg::SAMPLE_BITS-1:0] r_rd;

    // Input stage
    logic                                   r_a_valid;
    logic signed [vad_pkg::SAMPLE_BITS-1:0] r_a_sample;
    logic                                   r_a_zero;
    logic                                   r_a_last;

    // Result stage
    logic                                   r_b_valid;
    logic signed [vad_pkg::DIFF_BITS-1:0]   r_b_diff;
    logic                                   r_b_last;

    logic                                   a_adv;
    logic signed [vad_pkg::DIFF_BITS-1:0]   n_diff;

    // Hold off new transactions during reset and while both stages are full and the output stalls
    assign a_adv      = r_a_valid && (!r_b_valid || o_out.ready);
    assign o_in_ready = i_rst_n && (!r_a_valid || a_adv);

    // Read the old neighbour, then overwrite the slot
    always_ff @(posedge i_clk) begin
        if (i_step.wr_en) begin
            r_rd             <= mem[i_step.addr];
            mem[i_step.addr] <= i_sample;
        end
    end

    // Hold the item waiting for its neighbour read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_step.emit) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.emit) begin
            r_a_sample <= i_sample;
            r_a_zero   <= i_step.zero;
            r_a_last   <= i_step.last;
        end
    end

    // Subtract, or force zero at the far boundary
    always_comb begin
        if (r_a_zero)
            n_diff = '0;
        else
            n_diff = vad_pkg::DIFF_BITS'(r_a_sample)
                     - vad_pkg::DIFF_BITS'($signed(r_rd));
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_diff <= n_diff;
            r_b_last <= r_a_last;
        end
    end

    assign o_out.valid      = r_b_valid;
    assign o_out.difference = r_b_diff;
    assign o_out.last       = r_b_last;

endmodule

@@ rtl/vad_checker.sv @@
`include "volume_axis_difference_core_defines.svh"

module vad_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [vad_pkg::DIFF_BITS-1:0]        i_out_diff,
    input logic                                 i_out_last
);

    // A stalled result holds
    `VAD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_diff) && $stable(i_out_last), "result changed while stalled")

    // A new result follows an accepted transaction through the input stage and the output register
    `VAD_ASSERT_SAME(a_out_latency, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "result without a matching transaction")

    // Nothing follows the final result
    `VAD_ASSERT_NEXT(a_quiet_after_last, i_out_valid && i_out_ready && i_out_last, !i_out_valid, "result after the final one")

endmodule

bind volume_axis_difference_core vad_checker u_vad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_diff  (o_out.difference),
    .i_out_last  (o_out.last)
);
